// ===== rtl/lgs_pkg.sv =====
// Shared constants, types and codes for the toroidal life grid block.
// Used by lgs_row_cell, lgs_row_rule and life_generation_step.
// No dependencies.
`default_nettype none

package lgs_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 64;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);

	// Register widths; the saturated sizes fit in the same widths.
	localparam int ROWS_CFG_W = 6;
	localparam int COLS_CFG_W = 7;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;

	localparam logic [ROWS_CFG_W-1:0] MIN_ROWS = ROWS_CFG_W'(3);
	localparam logic [COLS_CFG_W-1:0] MIN_COLS = COLS_CFG_W'(3);
	localparam logic [ROWS_CFG_W-1:0] TOP_ROWS = ROWS_CFG_W'(MAX_ROWS);
	localparam logic [COLS_CFG_W-1:0] TOP_COLS = COLS_CFG_W'(MAX_COLS);
	localparam logic [ROWS_CFG_W-1:0] RST_ROWS = ROWS_CFG_W'(25);
	localparam logic [COLS_CFG_W-1:0] RST_COLS = COLS_CFG_W'(51);

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef logic [MAX_COLS-1:0] row_t;

	// Control of one row cell in the ring.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lgs_row_cell.sv =====
// One cell of the row ring: holds one grid row and takes its neighbor's row on a shift.
// Depends on lgs_pkg.
`default_nettype none

module lgs_row_cell
	import lgs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire row_t       shift_in,
	input  wire row_t       load_row,
	output row_t            row_out
);

	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.load) begin
			row_q <= load_row;
		end else if (ctrl.shift) begin
			row_q <= shift_in;
		end
	end

	assign row_out = row_q;

endmodule

`default_nettype wire

// ===== rtl/lgs_row_rule.sv =====
// Next-generation logic for one row from its upper, own and lower rows, wrapped at the
// active column count. Columns outside the active area keep their value. Depends on lgs_pkg.
`default_nettype none

module lgs_row_rule
	import lgs_pkg::*;
(
	input  wire row_t                  up_row,
	input  wire row_t                  mid_row,
	input  wire row_t                  dn_row,
	input  wire logic [COLS_CFG_W-1:0] nc,
	output row_t                       next_row
);

	function automatic logic life_rule(input logic alive, input logic [3:0] n);
		logic res;
		if (alive) begin
			res = (n == 4'd2) || (n == 4'd3);
		end else begin
			res = (n == 4'd3);
		end
		return res;
	endfunction

	logic [COLS_CFG_W-1:0] nc_m1_full;
	logic [COL_W-1:0]      nc_m1;

	assign nc_m1_full = nc - COLS_CFG_W'(1);
	assign nc_m1      = nc_m1_full[COL_W-1:0];

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		logic       ul, ur, ml, mr, dl, dr;
		logic [3:0] cnt;

		if (c == 0) begin : g_left_wrap
			assign ul = up_row[nc_m1];
			assign ml = mid_row[nc_m1];
			assign dl = dn_row[nc_m1];
		end else begin : g_left
			assign ul = up_row[c-1];
			assign ml = mid_row[c-1];
			assign dl = dn_row[c-1];
		end

		if (c == MAX_COLS-1) begin : g_right_edge
			assign ur = up_row[0];
			assign mr = mid_row[0];
			assign dr = dn_row[0];
		end else begin : g_right
			logic wrap;
			assign wrap = (nc_m1 == COL_W'(c));
			assign ur = wrap ? up_row[0]  : up_row[c+1];
			assign mr = wrap ? mid_row[0] : mid_row[c+1];
			assign dr = wrap ? dn_row[0]  : dn_row[c+1];
		end

		assign cnt = {3'b0, ul} + {3'b0, up_row[c]} + {3'b0, ur}
			+ {3'b0, ml} + {3'b0, mr}
			+ {3'b0, dl} + {3'b0, dn_row[c]} + {3'b0, dr};

		assign next_row[c] = (COLS_CFG_W'(c) < nc) ? life_rule(mid_row[c], cnt) : mid_row[c];
	end

endmodule

`default_nettype wire

// ===== rtl/life_generation_step.sv =====
// Top level of the toroidal life grid: ring of row cells, sequencer and config registers.
// Depends on lgs_pkg, lgs_row_cell and lgs_row_rule.
`default_nettype none

// The grid lives in a ring of MAX_ROWS row cells that rotates one row per cycle while it
// seeks a row or steps, and all work happens on the row at the head of the ring. A write or
// read whose cell lies outside the active area, and an unused op, gives its result in the
// cycle after start. A write or read inside the area first rotates the ring until the
// addressed row is at the head (as far as the distance from the row left at the head by the
// previous item), then registers its result from ST_SEEK once that row is at the head. A step
// rotates to row 0 the same way, then in ST_STEP passes every row through the rule logic,
// updating the active ones and row 0 on a second pass, and registers its result on that
// second pass of row 0. busy stays high until done pulses;
// done marks each result for one cycle and the receiver has no way to hold it off.
module life_generation_step
	import lgs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            op,
	input  wire logic [ROW_W-1:0]      row,
	input  wire logic [COL_W-1:0]      col,
	input  wire logic                  value,
	output logic                       done,
	output logic                       cell_alive,
	output logic                       out_of_range,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ROWS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SEEK, ST_STEP} state_t;

	state_t                  state_q;
	logic [ROWS_CFG_W-1:0]   rows_q;
	logic [COLS_CFG_W-1:0]   cols_q;
	logic [ROWS_CFG_W-1:0]   nr;
	logic [COLS_CFG_W-1:0]   nc;
	logic [ROW_W-1:0]        head_q;
	logic [ROW_W-1:0]        target_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              op_q;
	logic [COL_W-1:0]        col_q;
	logic                    value_q;
	logic                    done_q;
	logic                    alive_q;
	logic                    oor_q;
	row_t                    prev_q;
	row_t                    orig0_q;
	row_t                    orig1_q;

	row_t                    ring [MAX_ROWS];
	row_t                    tail_row;
	row_t                    write_row;
	row_t                    dn_row;
	row_t                    up_row;
	row_t                    rule_row;
	logic                    rotate;
	logic                    write_now;
	logic                    hit;
	logic                    accept;
	logic                    oor_in;
	logic                    is_access;
	logic [ROW_W-1:0]        h;
	logic                    h_active;
	logic                    last_pass;
	logic                    process;
	logic [ROWS_CFG_W-1:0]   nr_m1_full;

	// Registers outside their range saturate to the legal sizes.
	assign nr = (rows_q < MIN_ROWS) ? MIN_ROWS : ((rows_q > TOP_ROWS) ? TOP_ROWS : rows_q);
	assign nc = (cols_q < MIN_COLS) ? MIN_COLS : ((cols_q > TOP_COLS) ? TOP_COLS : cols_q);
	assign nr_m1_full = nr - ROWS_CFG_W'(1);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RST_ROWS;
			cols_q <= RST_COLS;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ROWS) begin
				rows_q <= cfg_data[ROWS_CFG_W-1:0];
			end else if (cfg_index == CFG_COLS) begin
				cols_q <= cfg_data[COLS_CFG_W-1:0];
			end
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign is_access = (op == OP_WRITE) || (op == OP_READ);
	assign oor_in    = is_access && (({1'b0, row} >= nr) || ({1'b0, col} >= nc));

	assign hit       = (head_q == target_q);
	assign rotate    = ((state_q == ST_SEEK) && !hit) || (state_q == ST_STEP);
	assign write_now = (state_q == ST_SEEK) && hit && (op_q == OP_WRITE);

	// During a step the head visits row 0 twice: first it passes unchanged and is saved,
	// and on the last pass it is updated from the saved rows, since its neighbors have
	// been replaced by then.
	assign h         = cnt_q[ROW_W-1:0];
	assign last_pass = (cnt_q == LAST_CNT);
	assign h_active  = ({1'b0, h} < nr);
	assign process   = last_pass || ((h != '0) && h_active);

	assign up_row = prev_q;
	always_comb begin
		if (last_pass) begin
			dn_row = orig1_q;
		end else if (h == nr_m1_full[ROW_W-1:0]) begin
			dn_row = orig0_q;
		end else begin
			dn_row = ring[1];
		end
	end

	lgs_row_rule u_rule (
		.up_row   (up_row),
		.mid_row  (ring[0]),
		.dn_row   (dn_row),
		.nc       (nc),
		.next_row (rule_row)
	);

	assign tail_row = ((state_q == ST_STEP) && process) ? rule_row : ring[0];

	always_comb begin
		write_row        = ring[0];
		write_row[col_q] = value_q;
	end

	for (genvar k = 0; k < MAX_ROWS; k++) begin : g_ring
		cell_ctrl_t ctrl;
		row_t       shift_in;

		assign ctrl.shift = rotate;
		if (k == 0) begin : g_head
			assign ctrl.load = write_now;
		end else begin : g_body
			assign ctrl.load = 1'b0;
		end

		if (k == MAX_ROWS-1) begin : g_tail
			assign shift_in = tail_row;
		end else begin : g_link
			assign shift_in = ring[k+1];
		end

		lgs_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.shift_in (shift_in),
			.load_row (write_row),
			.row_out  (ring[k])
		);
	end

	// Saved rows for the wrapped neighbors of the first and last active rows.
	always_ff @(posedge clk) begin
		if (state_q == ST_STEP && !last_pass) begin
			if (h_active) begin
				prev_q <= ring[0];
			end
			if (cnt_q == CNT_W'(0)) begin
				orig0_q <= ring[0];
			end
			if (cnt_q == CNT_W'(1)) begin
				orig1_q <= ring[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			col_q   <= col;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			target_q <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			alive_q  <= 1'b0;
			oor_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (rotate) begin
				head_q <= (head_q == LAST_ROW) ? '0 : head_q + ROW_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_STEP || (is_access && !oor_in)) begin
							state_q  <= ST_SEEK;
							target_q <= (op == OP_STEP) ? '0 : row;
						end else begin
							done_q  <= 1'b1;
							alive_q <= 1'b0;
							oor_q   <= oor_in;
						end
					end
				end
				ST_SEEK: begin
					if (hit) begin
						if (op_q == OP_STEP) begin
							state_q <= ST_STEP;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
							oor_q   <= 1'b0;
							alive_q <= (op_q == OP_READ) ? ring[0][col_q] : 1'b0;
						end
					end
				end
				ST_STEP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_pass) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						alive_q <= 1'b0;
						oor_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign cell_alive   = alive_q;
	assign out_of_range = oor_q;

endmodule

`default_nettype wire
